[rtl/gregorian_date_counter_unit_defines.svh]
// Assertion macros shared by the date counter RTL.
`ifndef GREGORIAN_DATE_COUNTER_UNIT_DEFINES_SVH
`define GREGORIAN_DATE_COUNTER_UNIT_DEFINES_SVH

`define GDC_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("gdc: invariant violated");

`define GDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gdc: sequence check failed");

`endif

[rtl/gdc_pkg.sv]
// Shared types, constants and calendar functions for the date counter.
package gdc_pkg;

    localparam int COUNT_BITS_DEF = 12;
    localparam int YEAR_BITS_DEF  = 16;
    localparam int MIN_YEAR       = 1990;
    localparam int CYCLE_YEARS    = 400;
    localparam int REM_BITS       = 9;
    localparam int DAY_BITS       = 5;
    localparam int MONTH_BITS     = 4;

    localparam logic [REM_BITS-1:0]   REM_RESET = REM_BITS'(MIN_YEAR % CYCLE_YEARS);
    localparam logic [REM_BITS-1:0]   REM_LAST  = REM_BITS'(CYCLE_YEARS - 1);
    localparam logic [MONTH_BITS-1:0] JANUARY   = 4'd1;
    localparam logic [MONTH_BITS-1:0] FEBRUARY  = 4'd2;
    localparam logic [MONTH_BITS-1:0] DECEMBER  = 4'd12;
    localparam logic [DAY_BITS-1:0]   FIRST_DAY = 5'd1;
    localparam logic [DAY_BITS-1:0]   LONG_LEN  = 5'd31;

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_ADVANCE = 2'd1,
        REQ_RETREAT = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LOAD = 2'd1,
        ST_LIMIT    = 2'd2
    } status_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mod_stat_t;

    function automatic logic leap_of_rem(input logic [REM_BITS-1:0] rem);
        logic century;
        century = (rem == REM_BITS'(100)) || (rem == REM_BITS'(200)) ||
                  (rem == REM_BITS'(300));
        return (rem[1:0] == 2'b00) && !century;
    endfunction

    function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] month,
                                                      input logic leap);
        logic [DAY_BITS-1:0] len;
        case (month)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            FEBRUARY:                len = leap ? 5'd29 : 5'd28;
            default:                 len = LONG_LEN;
        endcase
        return len;
    endfunction

endpackage

[rtl/gdc_mod400.sv]
// Remainder of a year by 400 through a reciprocal multiplication, in a multiply step and a subtract step.
module gdc_mod400 import gdc_pkg::*; #(
    parameter int YEAR_BITS = YEAR_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [YEAR_BITS-1:0] value,
    output mod_stat_t            stat,
    output logic [REM_BITS-1:0]  rem
);

    // The year is split as 16 * high + low, so the remainder is 16 * (high mod 25) + low.
    // The quotient high / 25 is floor(high * ceil(2^33 / 25) / 2^33), exact below 2^30.
    localparam int HIGH_W  = 28;
    localparam int RECIP_W = 29;
    localparam int SHIFT   = 33;
    localparam int PROD_W  = HIGH_W + RECIP_W;
    localparam int QUOT_W  = PROD_W - SHIFT;
    localparam logic [RECIP_W-1:0] RECIP_25 = 29'd343597384;

    logic [31:0]          value_ext;
    logic [PROD_W-1:0]    product;
    logic [HIGH_W-1:0]    quot_x25;
    logic [4:0]           rem_low;
    logic [HIGH_W-1:0]    high_reg, high_next;
    logic [3:0]           low_reg, low_next;
    logic [QUOT_W-1:0]    quot_reg, quot_next;
    logic [REM_BITS-1:0]  rem_reg, rem_next;
    logic                 mul_reg, mul_next;
    logic                 sub_reg, sub_next;
    logic                 done_reg, done_next;

    assign value_ext = 32'(value);
    assign product   = PROD_W'(high_reg) * PROD_W'(RECIP_25);
    assign quot_x25  = HIGH_W'({quot_reg, 4'b0000}) + HIGH_W'({quot_reg, 3'b000}) +
                       HIGH_W'(quot_reg);
    assign rem_low   = 5'(high_reg - quot_x25);

    always_comb begin
        high_next = high_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        mul_next  = 1'b0;
        sub_next  = 1'b0;
        done_next = 1'b0;
        if (start) begin
            high_next = value_ext[31:4];
            low_next  = value_ext[3:0];
            mul_next  = 1'b1;
        end else if (mul_reg) begin
            quot_next = product[PROD_W-1:SHIFT];
            sub_next  = 1'b1;
        end else if (sub_reg) begin
            rem_next  = {rem_low, low_reg};
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_reg  <= 1'b0;
            sub_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            mul_reg  <= mul_next;
            sub_reg  <= sub_next;
            done_reg <= done_next;
        end
        high_reg <= high_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign stat.busy = mul_reg || sub_reg;
    assign stat.done = done_reg;
    assign rem       = rem_reg;

endmodule

[rtl/gregorian_date_counter_unit.sv]
// Gregorian date counter: load with validation, advance by N days, retreat one day.
// Load waits in S_LOAD for the mod-400 unit; advance by N steps a day at a time in S_STEP;
// retreat passes through S_RETREAT. Each ends in S_FINISH, as do an advance by zero and
// the unused request code. One request is in work at a time, the next is taken once the
// result is in the output register; a stalled output beat holds the finished request.
// Synchronous active-low reset sets the date to January 1, 1990 and clears the handshakes.
`include "gregorian_date_counter_unit_defines.svh"

module gregorian_date_counter_unit import gdc_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int YEAR_BITS  = YEAR_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_req_type,
    input  logic [DAY_BITS-1:0]   s_load_day,
    input  logic [MONTH_BITS-1:0] s_load_month,
    input  logic [YEAR_BITS-1:0]  s_load_year,
    input  logic [COUNT_BITS-1:0] s_day_count,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DAY_BITS-1:0]   m_cur_day,
    output logic [MONTH_BITS-1:0] m_cur_month,
    output logic [YEAR_BITS-1:0]  m_cur_year,
    output logic                  m_leap_flag,
    output logic [1:0]            m_status
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_LOAD    = 5'b00010,
        S_STEP    = 5'b00100,
        S_RETREAT = 5'b01000,
        S_FINISH  = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [DAY_BITS-1:0]   day_reg, day_next;
    logic [MONTH_BITS-1:0] month_reg, month_next;
    logic [YEAR_BITS-1:0]  year_reg, year_next;
    logic [REM_BITS-1:0]   rem_reg, rem_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    status_t               status_reg, status_next;
    logic [DAY_BITS-1:0]   ld_day_reg, ld_day_next;
    logic [MONTH_BITS-1:0] ld_month_reg, ld_month_next;
    logic [YEAR_BITS-1:0]  ld_year_reg, ld_year_next;

    logic                  m_valid_reg, m_valid_next;
    logic [DAY_BITS-1:0]   m_day_reg, m_day_next;
    logic [MONTH_BITS-1:0] m_month_reg, m_month_next;
    logic [YEAR_BITS-1:0]  m_year_reg, m_year_next;
    logic                  m_leap_reg, m_leap_next;
    logic [1:0]            m_status_reg, m_status_next;

    logic                  accept;
    logic                  mod_start;
    mod_stat_t             mod_stat;
    logic [REM_BITS-1:0]   mod_rem;
    logic                  cur_leap;
    logic [DAY_BITS-1:0]   cur_len;
    logic [DAY_BITS-1:0]   prev_len;
    logic [MONTH_BITS-1:0] prev_month;
    logic                  load_ok;
    logic                  out_free;
    logic                  date_ok;

    gdc_mod400 #(
        .YEAR_BITS(YEAR_BITS)
    ) u_mod400 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .value   (s_load_year),
        .stat    (mod_stat),
        .rem     (mod_rem)
    );

    assign s_ready    = (state_reg == S_IDLE);
    assign accept     = s_valid && s_ready;
    assign mod_start  = accept && (s_req_type == REQ_LOAD);
    assign out_free   = !m_valid_reg || m_ready;
    assign cur_leap   = leap_of_rem(rem_reg);
    assign cur_len    = month_len(month_reg, cur_leap);
    assign prev_month = month_reg - 1'b1;
    assign prev_len   = month_len(prev_month, cur_leap);
    assign load_ok    = (ld_year_reg >= YEAR_BITS'(MIN_YEAR)) &&
                        (ld_month_reg >= JANUARY) && (ld_month_reg <= DECEMBER) &&
                        (ld_day_reg >= FIRST_DAY) &&
                        (ld_day_reg <= month_len(ld_month_reg, leap_of_rem(mod_rem)));
    assign date_ok    = (day_reg >= FIRST_DAY) && (day_reg <= cur_len) &&
                        (month_reg >= JANUARY) && (month_reg <= DECEMBER);

    always_comb begin
        state_next    = state_reg;
        day_next      = day_reg;
        month_next    = month_reg;
        year_next     = year_reg;
        rem_next      = rem_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        ld_day_next   = ld_day_reg;
        ld_month_next = ld_month_reg;
        ld_year_next  = ld_year_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_day_next    = m_day_reg;
        m_month_next  = m_month_reg;
        m_year_next   = m_year_reg;
        m_leap_next   = m_leap_reg;
        m_status_next = m_status_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    status_next   = ST_OK;
                    ld_day_next   = s_load_day;
                    ld_month_next = s_load_month;
                    ld_year_next  = s_load_year;
                    count_next    = s_day_count;
                    unique case (s_req_type)
                        REQ_LOAD:    state_next = S_LOAD;
                        REQ_ADVANCE: state_next = (s_day_count == '0) ? S_FINISH : S_STEP;
                        REQ_RETREAT: state_next = S_RETREAT;
                        default:     state_next = S_FINISH;
                    endcase
                end
            end
            S_LOAD: begin
                if (mod_stat.done) begin
                    if (load_ok) begin
                        day_next   = ld_day_reg;
                        month_next = ld_month_reg;
                        year_next  = ld_year_reg;
                        rem_next   = mod_rem;
                    end else begin
                        status_next = ST_BAD_LOAD;
                    end
                    state_next = S_FINISH;
                end
            end
            S_STEP: begin
                count_next = count_reg - 1'b1;
                if (count_reg == COUNT_BITS'(1)) begin
                    state_next = S_FINISH;
                end
                if (day_reg < cur_len) begin
                    day_next = day_reg + 1'b1;
                end else if (month_reg < DECEMBER) begin
                    day_next   = FIRST_DAY;
                    month_next = month_reg + 1'b1;
                end else if (year_reg == '1) begin
                    status_next = ST_LIMIT;
                    state_next  = S_FINISH;
                end else begin
                    day_next   = FIRST_DAY;
                    month_next = JANUARY;
                    year_next  = year_reg + 1'b1;
                    rem_next   = (rem_reg == REM_LAST) ? '0 : rem_reg + 1'b1;
                end
            end
            S_RETREAT: begin
                state_next = S_FINISH;
                if (day_reg > FIRST_DAY) begin
                    day_next = day_reg - 1'b1;
                end else if (month_reg > JANUARY) begin
                    month_next = prev_month;
                    day_next   = prev_len;
                end else if (year_reg <= YEAR_BITS'(MIN_YEAR)) begin
                    status_next = ST_LIMIT;
                end else begin
                    year_next  = year_reg - 1'b1;
                    month_next = DECEMBER;
                    day_next   = LONG_LEN;
                    rem_next   = (rem_reg == '0) ? REM_LAST : rem_reg - 1'b1;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_day_next    = day_reg;
                    m_month_next  = month_reg;
                    m_year_next   = year_reg;
                    m_leap_next   = cur_leap;
                    m_status_next = status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            day_reg     <= FIRST_DAY;
            month_reg   <= JANUARY;
            year_reg    <= YEAR_BITS'(MIN_YEAR);
            rem_reg     <= REM_RESET;
            status_reg  <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            day_reg     <= day_next;
            month_reg   <= month_next;
            year_reg    <= year_next;
            rem_reg     <= rem_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
        end
        count_reg    <= count_next;
        ld_day_reg   <= ld_day_next;
        ld_month_reg <= ld_month_next;
        ld_year_reg  <= ld_year_next;
        m_day_reg    <= m_day_next;
        m_month_reg  <= m_month_next;
        m_year_reg   <= m_year_next;
        m_leap_reg   <= m_leap_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_cur_day   = m_day_reg;
    assign m_cur_month = m_month_reg;
    assign m_cur_year  = m_year_reg;
    assign m_leap_flag = m_leap_reg;
    assign m_status    = m_status_reg;

    `GDC_ASSERT_ALWAYS(a_date_in_range, date_ok)
    `GDC_ASSERT_ALWAYS(a_step_count_live, (state_reg != S_STEP) || (count_reg != '0))
    `GDC_ASSERT_NEXT(a_busy_after_accept, accept, !s_ready)
    `GDC_ASSERT_ALWAYS(a_mod_only_in_load, !mod_stat.busy || (state_reg == S_LOAD))

endmodule
